// ----- sv/imu_window_average_magnitude_unit_macros.svh -----
`ifndef IMU_WINDOW_AVERAGE_MAGNITUDE_UNIT_MACROS_SVH
`define IMU_WINDOW_AVERAGE_MAGNITUDE_UNIT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define IWAM_ASSERT_CLK(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define IWAM_ASSERT_NEVER(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- sv/iwam_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package iwam_pkg;

    localparam int WINDOW     = 16;
    localparam int WIN_LOG2   = $clog2(WINDOW);
    localparam int WP_W       = WIN_LOG2;
    localparam int SAMPLE_W   = 16;
    localparam int SUM_W      = SAMPLE_W + WIN_LOG2;
    localparam int NCHAN      = 7;
    localparam int NMAG       = 2;
    localparam int NSQ        = 6;
    localparam int SQ_W       = 32;
    localparam int SQRT_STEPS = 16;

    localparam logic [SQ_W-1:0]     SQRT_BIT_INIT = 32'h4000_0000;
    localparam logic [SAMPLE_W-1:0] ALARM_RESET   = 16'd12544;

    localparam int CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] ADDR_ALARM = 2'd0;

    // Channel order inside a history entry
    localparam int CH_ACCEL_X = 0;
    localparam int CH_ACCEL_Y = 1;
    localparam int CH_ACCEL_Z = 2;
    localparam int CH_RATE_X  = 3;
    localparam int CH_RATE_Y  = 4;
    localparam int CH_RATE_Z  = 5;
    localparam int CH_TEMP    = 6;
    localparam int MAG_ACCEL  = 0;
    localparam int MAG_RATE   = 1;

    typedef struct packed {
        logic [NCHAN-1:0][SAMPLE_W-1:0] ch;
        logic [NMAG-1:0][SAMPLE_W-1:0]  mag;
    } iwam_entry_t;

endpackage

`default_nettype wire

// ----- sv/iwam_sample_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface iwam_sample_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
    logic signed [15:0] temperature;

    modport source (
        output valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, temperature,
        input  ready
    );
    modport sink (
        input  valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, temperature,
        output ready
    );
endinterface

`default_nettype wire

// ----- sv/iwam_result_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface iwam_result_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] avg_accel_x;
    logic signed [15:0] avg_accel_y;
    logic signed [15:0] avg_accel_z;
    logic signed [15:0] avg_rate_x;
    logic signed [15:0] avg_rate_y;
    logic signed [15:0] avg_rate_z;
    logic signed [15:0] avg_temperature;
    logic        [15:0] accel_magnitude;
    logic        [15:0] rate_magnitude;
    logic        [15:0] avg_accel_magnitude;
    logic        [15:0] avg_rate_magnitude;
    logic               high_accel;

    modport source (
        output valid, avg_accel_x, avg_accel_y, avg_accel_z, avg_rate_x, avg_rate_y,
               avg_rate_z, avg_temperature, accel_magnitude, rate_magnitude,
               avg_accel_magnitude, avg_rate_magnitude, high_accel,
        input  ready
    );
    modport sink (
        input  valid, avg_accel_x, avg_accel_y, avg_accel_z, avg_rate_x, avg_rate_y,
               avg_rate_z, avg_temperature, accel_magnitude, rate_magnitude,
               avg_accel_magnitude, avg_rate_magnitude, high_accel,
        output ready
    );
endinterface

`default_nettype wire

// ----- sv/imu_window_average_magnitude_unit.sv -----
// IMU window averager with accel and rate vector magnitudes.
// sample channel (sink): one IMU sample per transfer, seven signed 16-bit channels.
// result channel (source): one result per sample: seven window means, the floor
//   square-root magnitudes of the newest accel and rate vectors, the window means
//   of those magnitudes and the high acceleration flag.
// APB port: register 0 (byte address 0) holds the 16-bit accel alarm level.
// The block takes a new sample only when idle, after the previous sample has
//   gone through six squares on one shared multiplier, two 16-step bit-serial
//   square roots on one shared root unit and one history update; the result
//   is registered by that update.
// A finished result sits in the output register; the next sample is taken and
//   worked on meanwhile, and only its final update waits while the receiver
//   stalls the previous result.
// Reset clears the write position, running sums and the valid bits of the
//   16-entry history ring, so early means include zeros; alarm level returns
//   to 12544. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

`include "imu_window_average_magnitude_unit_macros.svh"

module imu_window_average_magnitude_unit
    import iwam_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    iwam_sample_if.sink                sample,
    iwam_result_if.source              result,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_SQRT_ACCEL,
        ST_SQRT_RATE,
        ST_UPDATE
    } state_t;

    state_t                    state_reg;
    logic [3:0]                cnt_reg;
    logic [WP_W-1:0]           wp_reg;
    logic [WP_W-1:0]           wp_next;
    logic [SAMPLE_W-1:0]       alarm_reg;
    logic signed [SAMPLE_W-1:0] smp_reg [NCHAN];

    // shared multiplier
    logic signed [SAMPLE_W-1:0]   mul_op;
    logic signed [2*SAMPLE_W-1:0] mul_full;
    logic [SQ_W-1:0]              prod_reg;
    logic [SQ_W-1:0]              acc_a_reg;
    logic [SQ_W-1:0]              acc_r_reg;

    // shared root unit
    logic [SQ_W-1:0] sq_v_reg;
    logic [SQ_W-1:0] sq_root_reg;
    logic [SQ_W-1:0] sq_bit_reg;
    logic [SQ_W-1:0] sq_trial;
    logic            sq_take;
    logic [SQ_W-1:0] sq_v_next;
    logic [SQ_W-1:0] sq_root_next;
    logic [SAMPLE_W-1:0] mag_a_reg;
    logic [SAMPLE_W-1:0] mag_r_reg;

    // history ring
    iwam_entry_t     mem [WINDOW];
    iwam_entry_t     rd_reg;
    logic            rd_vld_reg;
    logic [WINDOW-1:0] vld_reg;
    iwam_entry_t     old_entry;
    iwam_entry_t     new_entry;
    logic            wr_en;

    logic signed [SUM_W-1:0] csum_reg  [NCHAN];
    logic signed [SUM_W-1:0] csum_next [NCHAN];
    logic        [SUM_W-1:0] msum_reg  [NMAG];
    logic        [SUM_W-1:0] msum_next [NMAG];

    logic out_valid_reg;
    logic in_xfer;
    logic out_xfer;
    logic cfg_wr;

    assign sample.ready = (state_reg == ST_IDLE);
    assign in_xfer      = sample.valid && sample.ready;
    assign out_xfer     = result.valid && result.ready;
    assign result.valid = out_valid_reg;
    assign wr_en        = (state_reg == ST_UPDATE) && (!out_valid_reg || result.ready);

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr == ADDR_ALARM) ? {16'b0, alarm_reg} : 32'b0;

    assign wp_next = (wp_reg == WP_W'(WINDOW - 1)) ? '0 : wp_reg + 1'b1;

    assign mul_op   = smp_reg[cnt_reg[2:0]];
    assign mul_full = mul_op * mul_op;

    always_comb
    begin
        sq_trial = sq_root_reg + sq_bit_reg;
        sq_take  = (sq_v_reg >= sq_trial);
        if (sq_take)
        begin
            sq_v_next    = sq_v_reg - sq_trial;
            sq_root_next = (sq_root_reg >> 1) + sq_bit_reg;
        end
        else
        begin
            sq_v_next    = sq_v_reg;
            sq_root_next = sq_root_reg >> 1;
        end
    end

    // Entries never written read as zero.
    assign old_entry = rd_vld_reg ? rd_reg : '0;

    always_comb
    begin
        for (int i = 0; i < NCHAN; i++)
        begin
            new_entry.ch[i] = smp_reg[i];
            csum_next[i] = csum_reg[i]
                         + {{WIN_LOG2{smp_reg[i][SAMPLE_W-1]}}, smp_reg[i]}
                         - {{WIN_LOG2{old_entry.ch[i][SAMPLE_W-1]}}, old_entry.ch[i]};
        end
        new_entry.mag[MAG_ACCEL] = mag_a_reg;
        new_entry.mag[MAG_RATE]  = mag_r_reg;
        for (int i = 0; i < NMAG; i++)
        begin
            msum_next[i] = msum_reg[i] + {{WIN_LOG2{1'b0}}, new_entry.mag[i]}
                         - {{WIN_LOG2{1'b0}}, old_entry.mag[i]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
            rd_reg <= mem[wp_next];
        if (wr_en)
            mem[wp_reg] <= new_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            wp_reg        <= '0;
            alarm_reg     <= ALARM_RESET;
            vld_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NCHAN; i++)
                csum_reg[i] <= '0;
            for (int i = 0; i < NMAG; i++)
                msum_reg[i] <= '0;
        end
        else
        begin
            if (cfg_wr && paddr == ADDR_ALARM)
                alarm_reg <= pwdata[SAMPLE_W-1:0];
            // a new result replacing the taken one keeps valid high
            if (out_xfer && !wr_en)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        smp_reg[CH_ACCEL_X] <= sample.accel_x;
                        smp_reg[CH_ACCEL_Y] <= sample.accel_y;
                        smp_reg[CH_ACCEL_Z] <= sample.accel_z;
                        smp_reg[CH_RATE_X]  <= sample.rate_x;
                        smp_reg[CH_RATE_Y]  <= sample.rate_y;
                        smp_reg[CH_RATE_Z]  <= sample.rate_z;
                        smp_reg[CH_TEMP]    <= sample.temperature;
                        wp_reg     <= wp_next;
                        rd_vld_reg <= vld_reg[wp_next];
                        acc_a_reg  <= '0;
                        acc_r_reg  <= '0;
                        cnt_reg    <= '0;
                        state_reg  <= ST_SQUARE;
                    end
                end
                ST_SQUARE:
                begin
                    // square of axis cnt, accumulate square of axis cnt-1
                    prod_reg <= SQ_W'(unsigned'(mul_full));
                    if (cnt_reg != 4'd0)
                    begin
                        if (cnt_reg <= 4'(NSQ / 2))
                            acc_a_reg <= acc_a_reg + prod_reg;
                        else
                            acc_r_reg <= acc_r_reg + prod_reg;
                    end
                    if (cnt_reg == 4'(NSQ))
                    begin
                        sq_v_reg    <= acc_a_reg;
                        sq_root_reg <= '0;
                        sq_bit_reg  <= SQRT_BIT_INIT;
                        cnt_reg     <= '0;
                        state_reg   <= ST_SQRT_ACCEL;
                    end
                    else
                        cnt_reg <= cnt_reg + 4'd1;
                end
                ST_SQRT_ACCEL:
                begin
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg == 4'(SQRT_STEPS - 1))
                    begin
                        mag_a_reg   <= sq_root_next[SAMPLE_W-1:0];
                        sq_v_reg    <= acc_r_reg;
                        sq_root_reg <= '0;
                        sq_bit_reg  <= SQRT_BIT_INIT;
                        state_reg   <= ST_SQRT_RATE;
                    end
                    else
                    begin
                        sq_v_reg    <= sq_v_next;
                        sq_root_reg <= sq_root_next;
                        sq_bit_reg  <= sq_bit_reg >> 2;
                    end
                end
                ST_SQRT_RATE:
                begin
                    cnt_reg     <= cnt_reg + 4'd1;
                    sq_v_reg    <= sq_v_next;
                    sq_root_reg <= sq_root_next;
                    sq_bit_reg  <= sq_bit_reg >> 2;
                    if (cnt_reg == 4'(SQRT_STEPS - 1))
                    begin
                        mag_r_reg <= sq_root_next[SAMPLE_W-1:0];
                        state_reg <= ST_UPDATE;
                    end
                end
                ST_UPDATE:
                begin
                    // hold until the previous result is taken
                    if (wr_en)
                    begin
                        vld_reg[wp_reg] <= 1'b1;
                        for (int i = 0; i < NCHAN; i++)
                            csum_reg[i] <= csum_next[i];
                        for (int i = 0; i < NMAG; i++)
                            msum_reg[i] <= msum_next[i];
                        result.avg_accel_x <= csum_next[CH_ACCEL_X][WIN_LOG2 +: SAMPLE_W];
                        result.avg_accel_y <= csum_next[CH_ACCEL_Y][WIN_LOG2 +: SAMPLE_W];
                        result.avg_accel_z <= csum_next[CH_ACCEL_Z][WIN_LOG2 +: SAMPLE_W];
                        result.avg_rate_x  <= csum_next[CH_RATE_X][WIN_LOG2 +: SAMPLE_W];
                        result.avg_rate_y  <= csum_next[CH_RATE_Y][WIN_LOG2 +: SAMPLE_W];
                        result.avg_rate_z  <= csum_next[CH_RATE_Z][WIN_LOG2 +: SAMPLE_W];
                        result.avg_temperature <= csum_next[CH_TEMP][WIN_LOG2 +: SAMPLE_W];
                        result.accel_magnitude <= mag_a_reg;
                        result.rate_magnitude  <= mag_r_reg;
                        result.avg_accel_magnitude <=
                            msum_next[MAG_ACCEL][WIN_LOG2 +: SAMPLE_W];
                        result.avg_rate_magnitude <=
                            msum_next[MAG_RATE][WIN_LOG2 +: SAMPLE_W];
                        result.high_accel <= (mag_a_reg > alarm_reg);
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `IWAM_ASSERT_CLK(a_wp_moves_on_transfer, !in_xfer |=> $stable(wp_reg),
        "write position moved without a sample transfer")
    `IWAM_ASSERT_CLK(a_result_from_update,
        $rose(out_valid_reg) |-> $past(state_reg == ST_UPDATE),
        "result raised outside the update step")
    `IWAM_ASSERT_NEVER(a_root_bit_onehot,
        (state_reg == ST_SQRT_ACCEL || state_reg == ST_SQRT_RATE) && !$onehot0(sq_bit_reg),
        "root trial bit not one-hot")
    `IWAM_ASSERT_NEVER(a_square_count, state_reg == ST_SQUARE && cnt_reg > 4'(NSQ),
        "square step count out of range")

endmodule

`default_nettype wire
